// ----- hw/rtl/aakh_pkg.sv -----
// Package for the axial angle kernel histogram.
// Word types, codes, sequencer states and fixed widths; used by the top level.
`timescale 1ns / 1ps
package aakh_pkg;

  localparam int NUM_BINS      = 360;
  localparam int BIN_IDX_W     = 9;
  localparam int BIN_W         = 48;
  localparam int TOTAL_W       = 56;
  localparam int DENS_W        = 25;
  localparam int SPREAD_W      = 7;
  localparam int SPREAD_RESET  = 11;
  localparam int SPREAD_MIN    = 1;
  localparam int SPREAD_MAX    = 90;
  localparam int ANGLE_W       = 16;
  localparam int WEIGHT_W      = 16;
  localparam int DEF_ANGLE_FRAC_BITS = 4;
  localparam int DEF_OUT_FRAC_BITS   = 24;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_FOLD,
    ST_CENTER,
    ST_RD,
    ST_MUL,
    ST_WR,
    ST_RDREQ,
    ST_RDWAIT,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [ANGLE_W-1:0] angle;
    logic [WEIGHT_W-1:0]      weight;
    logic [BIN_IDX_W-1:0]     bin_index;
  } cmd_t;

  typedef struct packed {
    logic [DENS_W-1:0] density;
    logic              saturated;
  } res_t;

endpackage

// ----- hw/rtl/aakh_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module aakh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/axial_angle_kernel_histogram.sv -----
// Top level of the axial angle kernel histogram.
// Depends on aakh_pkg and aakh_ram.
`timescale 1ns / 1ps
// 360-bin histogram of axial angles with a triangular kernel, one item at a
// time. cmd_ready is high only while the sequencer is idle and no total update
// is pending. An add folds its angle one bit at a time in the fold state,
// then for each of the two centers passes a setup state and, for each of
// its 2 * spread + 1 bins, the read, multiply and write states of the bin
// memory's read-modify-write, then the last total update. A read divides the
// bin by the total, one quotient bit per cycle (it skips the division when
// the index is out of range, the total is zero or the bin holds the whole
// total), and its word waits in an output register; a read stalls while the
// previous word is still unread. A clear, and reset, sweep the bin memory one
// entry per cycle without taking items. The spread register may be written at
// any time; it is sampled per add.
module axial_angle_kernel_histogram #(
  parameter int ANGLE_FRAC_BITS = aakh_pkg::DEF_ANGLE_FRAC_BITS,
  parameter int OUT_FRAC_BITS   = aakh_pkg::DEF_OUT_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_ready,
  input  aakh_pkg::cmd_t                   cmd,
  output logic                             res_valid,
  input  logic                             res_ready,
  output aakh_pkg::res_t                   res,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [aakh_pkg::SPREAD_W-1:0]    cfg_spread
);
  import aakh_pkg::*;

  localparam int HALF_C   = 180 << ANGLE_FRAC_BITS;
  localparam int FULL_C   = 360 << ANGLE_FRAC_BITS;
  localparam int CW       = $clog2(FULL_C + 1);
  localparam int HALF_R   = (1 << ANGLE_FRAC_BITS) >> 1;
  localparam int FOLD_OFS = ((32768 + HALF_C - 1) / HALF_C) * HALF_C;
  localparam int UW       = $clog2(32767 + FOLD_OFS + 1);
  localparam int PW       = WEIGHT_W + CW;
  localparam int QW       = OUT_FRAC_BITS + 1;
  localparam int CW0      = $clog2(NUM_BINS);
  localparam int CW1      = $clog2(UW);
  localparam int CW2      = $clog2(OUT_FRAC_BITS);
  localparam int CNTW     = (CW0 > CW1) ? ((CW0 > CW2) ? CW0 : CW2)
                                        : ((CW1 > CW2) ? CW1 : CW2);

  localparam logic [BIN_W-1:0]   BIN_MAX   = {BIN_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  state_t state, state_next;

  logic [CNTW-1:0]      cnt;
  logic [SPREAD_W-1:0]  spread;
  logic [SPREAD_W-1:0]  sp;
  logic [WEIGHT_W-1:0]  weight;
  logic [UW-1:0]        ushift;
  logic [CW-1:0]        fold;
  logic                 ctr;
  logic [CW-1:0]        cpos;
  logic [BIN_IDX_W-1:0] idx;
  logic [CW-1:0]        kdist;
  logic [PW-1:0]        inc;
  logic                 acc_valid;
  logic [BIN_W-1:0]     acc_amt;
  logic [TOTAL_W-1:0]   total;
  logic                 ovf;
  logic [BIN_IDX_W-1:0] rd_idx;
  logic [TOTAL_W-1:0]   rem;
  logic [QW-1:0]        q;

  logic                 ram_we;
  logic [BIN_IDX_W-1:0] ram_waddr;
  logic [BIN_W-1:0]     ram_wdata;
  logic                 ram_re;
  logic [BIN_IDX_W-1:0] ram_raddr;
  logic [BIN_W-1:0]     ram_rdata;

  logic                 cmd_acc;
  logic                 res_load;
  logic                 rd_short;
  logic [CW:0]          fold_t;
  logic [CW-1:0]        cen_c;
  logic [CW-1:0]        cen_rc;
  logic [BIN_IDX_W:0]   cen_st;
  logic [CW-1:0]        pos;
  logic [CW-1:0]        dabs;
  logic [CW-1:0]        sv;
  logic [BIN_W:0]       bsum;
  logic [TOTAL_W:0]     tsum;
  logic [TOTAL_W:0]     r2;
  logic [UW:0]          ang_ext;
  logic [SPREAD_W-1:0]  sp_clamp;

  aakh_ram #(
    .WIDTH (BIN_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign cmd_ready = (state == ST_IDLE) && !acc_valid;
  assign cmd_acc   = cmd_valid && cmd_ready;
  assign res_load  = (state == ST_DONE) && (!res_valid || res_ready);

  assign sp_clamp = (spread < SPREAD_W'(SPREAD_MIN)) ? SPREAD_W'(SPREAD_MIN)
                  : (spread > SPREAD_W'(SPREAD_MAX)) ? SPREAD_W'(SPREAD_MAX) : spread;

  // datapath helpers
  always_comb begin
    ang_ext = {{(UW + 1 - ANGLE_W){cmd.angle[ANGLE_W-1]}}, cmd.angle} + (UW + 1)'(FOLD_OFS);
    fold_t  = {fold, ushift[UW-1]};
    cen_c   = ctr ? (fold + CW'(HALF_C)) : fold;
    cen_rc  = (cen_c + CW'(HALF_R)) >> ANGLE_FRAC_BITS;
    cen_st  = (BIN_IDX_W + 1)'(cen_rc) + (BIN_IDX_W + 1)'(NUM_BINS) - (BIN_IDX_W + 1)'(sp);
    if (cen_st >= (BIN_IDX_W + 1)'(NUM_BINS)) begin
      cen_st = cen_st - (BIN_IDX_W + 1)'(NUM_BINS);
    end
    pos  = CW'(idx) << ANGLE_FRAC_BITS;
    dabs = (pos > cpos) ? (pos - cpos) : (cpos - pos);
    if (dabs > CW'(HALF_C)) begin
      dabs = CW'(FULL_C) - dabs;
    end
    sv   = CW'(sp) << ANGLE_FRAC_BITS;
    bsum = {1'b0, ram_rdata} + (BIN_W + 1)'(inc);
    tsum = {1'b0, total} + (TOTAL_W + 1)'(acc_amt);
    r2   = {rem, 1'b0};
    rd_short = (rd_idx >= BIN_IDX_W'(NUM_BINS)) || (total == '0)
            || ((TOTAL_W)'(ram_rdata) >= total);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLR:    if (cnt == CNTW'(NUM_BINS - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (cmd_acc) begin
          case (cmd.func)
            FUNC_ADD:   state_next = ST_FOLD;
            FUNC_READ:  state_next = ST_RDREQ;
            FUNC_CLEAR: state_next = ST_CLR;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_FOLD:   if (cnt == '0) state_next = ST_CENTER;
      ST_CENTER: state_next = ST_RD;
      ST_RD:     state_next = ST_MUL;
      ST_MUL:    state_next = ST_WR;
      ST_WR: begin
        if (cnt == '0) begin
          state_next = ctr ? ST_IDLE : ST_CENTER;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_RDREQ:  state_next = ST_RDWAIT;
      ST_RDWAIT: state_next = rd_short ? ST_DONE : ST_DIV;
      ST_DIV:    if (cnt == '0) state_next = ST_DONE;
      ST_DONE:   if (!res_valid || res_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = bsum[BIN_W] ? BIN_MAX : bsum[BIN_W-1:0];
    ram_re    = 1'b0;
    ram_raddr = idx;
    case (state)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = BIN_IDX_W'(cnt);
        ram_wdata = '0;
      end
      ST_RD:    ram_re = 1'b1;
      ST_WR:    ram_we = 1'b1;
      ST_RDREQ: begin
        ram_re    = (rd_idx < BIN_IDX_W'(NUM_BINS));
        ram_raddr = rd_idx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      spread    <= SPREAD_W'(SPREAD_RESET);
      total     <= '0;
      ovf       <= 1'b0;
      acc_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        spread <= cfg_spread;
      end
      acc_valid <= 1'b0;
      if (acc_valid) begin
        if (tsum[TOTAL_W]) begin
          total <= TOTAL_MAX;
          ovf   <= 1'b1;
        end else begin
          total <= tsum[TOTAL_W-1:0];
        end
      end
      if (res_valid && res_ready && !res_load) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_CLR: cnt <= cnt + 1'b1;
        ST_IDLE: begin
          if (cmd_acc) begin
            sp     <= sp_clamp;
            weight <= cmd.weight;
            rd_idx <= cmd.bin_index;
            ushift <= ang_ext[UW-1:0];
            fold   <= '0;
            ctr    <= 1'b0;
            cnt    <= (cmd.func == FUNC_CLEAR) ? '0 : CNTW'(UW - 1);
            if (cmd.func == FUNC_CLEAR) begin
              total <= '0;
              ovf   <= 1'b0;
            end
          end
        end
        ST_FOLD: begin
          fold   <= (fold_t >= (CW + 1)'(HALF_C)) ? CW'(fold_t - (CW + 1)'(HALF_C))
                                                  : fold_t[CW-1:0];
          ushift <= ushift << 1;
          cnt    <= cnt - 1'b1;
        end
        ST_CENTER: begin
          cpos <= cen_c;
          idx  <= cen_st[BIN_IDX_W-1:0];
          cnt  <= CNTW'({sp, 1'b0});
        end
        ST_RD:  kdist <= dabs;
        ST_MUL: inc   <= (kdist <= sv) ? (PW'(weight) * PW'(sv - kdist)) : '0;
        ST_WR: begin
          acc_valid <= 1'b1;
          if (bsum[BIN_W]) begin
            acc_amt <= ~ram_rdata;
            ovf     <= 1'b1;
          end else begin
            acc_amt <= BIN_W'(inc);
          end
          idx <= (idx == BIN_IDX_W'(NUM_BINS - 1)) ? '0 : idx + 1'b1;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            ctr <= 1'b1;
          end
        end
        ST_RDWAIT: begin
          rem <= TOTAL_W'(ram_rdata);
          cnt <= CNTW'(OUT_FRAC_BITS - 1);
          q   <= ((rd_idx < BIN_IDX_W'(NUM_BINS)) && (total != '0)
                  && (TOTAL_W'(ram_rdata) >= total)) ? (QW'(1) << OUT_FRAC_BITS) : '0;
        end
        ST_DIV: begin
          if (r2 >= (TOTAL_W + 1)'(total)) begin
            rem <= TOTAL_W'(r2 - (TOTAL_W + 1)'(total));
            q   <= {q[QW-2:0], 1'b1};
          end else begin
            rem <= r2[TOTAL_W-1:0];
            q   <= {q[QW-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
        end
        ST_DONE: begin
          if (res_load) begin
            res_valid     <= 1'b1;
            res.density   <= DENS_W'(q);
            res.saturated <= ovf;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_acc_single: assert property (@(posedge clk) disable iff (rst)
    acc_valid |=> !acc_valid) else $error("total update overlapped");
  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    (state != ST_CLR && !(cmd_acc && cmd.func == FUNC_CLEAR)) |=> (total >= $past(total)))
    else $error("total decreased without clear");
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < total)) else $error("division remainder out of range");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD) |-> (idx < BIN_IDX_W'(NUM_BINS))) else $error("bin index out of range");
`endif

endmodule
